[rtl/core/mexp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types, constants and the microcode table of the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Operand width of base, exponent, modulus and residue.
    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);
    localparam int PC_W          = 4;

    typedef logic [OPERAND_WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [PC_W-1:0]          t_pc;

    // Reset value of the modulus register.
    localparam t_word RESET_MODULUS = t_word'(23);
    // Start value of the bit counters: one step per operand bit.
    localparam t_cnt  CNT_START     = t_cnt'(OPERAND_WIDTH - 1);

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,      // take a request, snapshot the modulus
        OP_SETUP_RED,   // start base mod m (multiply 1 by the base)
        OP_MUL_STEP,    // one double-and-add step of the modular multiply
        OP_STORE_X,     // keep the reduced base, arm the exponent counter
        OP_SETUP_SQR,   // start acc * acc
        OP_SETUP_MULX,  // start x * acc
        OP_STORE_ACC,   // keep the product as new accumulator
        OP_NEXT_BIT,    // move to the next exponent bit
        OP_EMIT         // load the output register
    } t_op;

    // Jump conditions of the sequencer.
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_REQ,
        COND_CNT_NZ,
        COND_EBIT_ZERO,
        COND_BITS_LEFT,
        COND_OUT_BUSY
    } t_cond;

    // One control word of the microprogram.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    // Flags from the datapath that the sequencer branches on.
    typedef struct packed {
        logic req_valid;
        logic cnt_nz;
        logic ebit;
        logic bits_left;
        logic out_busy;
    } t_status;

    // Program addresses.
    localparam t_pc PC_WAIT     = t_pc'(0);
    localparam t_pc PC_RED_SET  = t_pc'(1);
    localparam t_pc PC_RED_LOOP = t_pc'(2);
    localparam t_pc PC_STORE_X  = t_pc'(3);
    localparam t_pc PC_SQR_SET  = t_pc'(4);
    localparam t_pc PC_SQR_LOOP = t_pc'(5);
    localparam t_pc PC_SQR_DONE = t_pc'(6);
    localparam t_pc PC_MUL_SET  = t_pc'(7);
    localparam t_pc PC_MUL_LOOP = t_pc'(8);
    localparam t_pc PC_MUL_DONE = t_pc'(9);
    localparam t_pc PC_NEXT     = t_pc'(10);
    localparam t_pc PC_EMIT     = t_pc'(11);
    localparam t_pc PC_LAST     = PC_EMIT;

    // Microprogram: square-and-multiply over the exponent, MSB first.
    function automatic t_ctrl rom_word(input t_pc pc);
        t_ctrl w;
        begin
            w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_WAIT};
            case (pc)
                PC_WAIT:     w = '{op: OP_ACCEPT,     cond: COND_NO_REQ,    target: PC_WAIT};
                PC_RED_SET:  w = '{op: OP_SETUP_RED,  cond: COND_NONE,      target: PC_WAIT};
                PC_RED_LOOP: w = '{op: OP_MUL_STEP,   cond: COND_CNT_NZ,    target: PC_RED_LOOP};
                PC_STORE_X:  w = '{op: OP_STORE_X,    cond: COND_NONE,      target: PC_WAIT};
                PC_SQR_SET:  w = '{op: OP_SETUP_SQR,  cond: COND_NONE,      target: PC_WAIT};
                PC_SQR_LOOP: w = '{op: OP_MUL_STEP,   cond: COND_CNT_NZ,    target: PC_SQR_LOOP};
                PC_SQR_DONE: w = '{op: OP_STORE_ACC,  cond: COND_EBIT_ZERO, target: PC_NEXT};
                PC_MUL_SET:  w = '{op: OP_SETUP_MULX, cond: COND_NONE,      target: PC_WAIT};
                PC_MUL_LOOP: w = '{op: OP_MUL_STEP,   cond: COND_CNT_NZ,    target: PC_MUL_LOOP};
                PC_MUL_DONE: w = '{op: OP_STORE_ACC,  cond: COND_NONE,      target: PC_WAIT};
                PC_NEXT:     w = '{op: OP_NEXT_BIT,   cond: COND_BITS_LEFT, target: PC_SQR_SET};
                PC_EMIT:     w = '{op: OP_EMIT,       cond: COND_OUT_BUSY,  target: PC_EMIT};
                default:     w = '{op: OP_NOP,        cond: COND_ALWAYS,    target: PC_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage : mexp_pkg
`default_nettype wire

[rtl/core/modular_exponentiation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Residue of base to the exponent modulo a configured modulus.
// ----------------------------------------------------------------------------
// Usage:
// A request enters on the s_axis channel with the base in tdata[31:0] and the
// exponent in tdata[63:32]; the residue leaves on m_axis tdata[31:0].
// The modulus is written through i_cfg_we / i_cfg_wdata while no request is
// in flight; reset loads it with 23. A zero modulus gives a residue of 0.
// One request is worked on at a time. The work is done by the bit-serial
// modular multiplier: 32 steps per product, one squaring for every exponent
// bit and one extra product for every set bit, plus the initial reduction of
// the base. The next request can be taken from the cycle in which the
// residue appears. s_axis_tready is high only while the sequencer waits
// for a request. A finished residue sits in the output register until
// taken, and the next request is accepted meanwhile; if the receiver still
// stalls when that one finishes, the sequencer holds at its emit step.
// After reset the sequencer waits for a request and the output is empty.
// ----------------------------------------------------------------------------
module modular_exponentiation
    import mexp_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration: modulus.
    input  wire         i_cfg_we,
    input  wire  [31:0] i_cfg_wdata,
    // Requests.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [31:0] base, [63:32] exponent
    // Results.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] residue
);

    t_word   r_modulus;
    t_ctrl   w_ctrl;
    t_status w_status;

    // Modulus register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= RESET_MODULUS;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_wdata;
        end
    end

    // The sequencer takes a request only in its wait step.
    assign s_axis_tready = (w_ctrl.op == OP_ACCEPT);

    mexp_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    mexp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_req_valid (s_axis_tvalid),
        .i_base      (s_axis_tdata[31:0]),
        .i_exponent  (s_axis_tdata[63:32]),
        .i_modulus   (r_modulus),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_residue   (m_axis_tdata)
    );

    // A result appears only after an emit step.
    a_rise_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(w_ctrl.op) == OP_EMIT))
        else $error("result appeared without an emit step");

    // No request is taken while a result is being emitted.
    a_no_accept_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_EMIT) |-> !s_axis_tready)
        else $error("request window open during emit");

    // A configuration write reaches the modulus register.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_modulus == $past(i_cfg_wdata)))
        else $error("modulus write lost");

endmodule : modular_exponentiation
`default_nettype wire

[rtl/core/mexp_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module mexp_sequencer
    import mexp_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_pc   r_pc;
    t_pc   n_pc;
    t_ctrl w_ctrl;
    logic  w_jump;

    // Control word of the current step.
    always_comb begin
        w_ctrl = rom_word(r_pc);
    end

    assign o_ctrl = w_ctrl;

    // Branch decision.
    always_comb begin
        case (w_ctrl.cond)
            COND_NONE:      w_jump = 1'b0;
            COND_ALWAYS:    w_jump = 1'b1;
            COND_NO_REQ:    w_jump = !i_status.req_valid;
            COND_CNT_NZ:    w_jump = i_status.cnt_nz;
            COND_EBIT_ZERO: w_jump = !i_status.ebit;
            COND_BITS_LEFT: w_jump = i_status.bits_left;
            COND_OUT_BUSY:  w_jump = i_status.out_busy;
            default:        w_jump = 1'b1;
        endcase
    end

    // Next step: jump target, or the following address with wrap at the end.
    always_comb begin
        if (w_jump) begin
            n_pc = w_ctrl.target;
        end else if (r_pc == PC_LAST) begin
            n_pc = PC_WAIT;
        end else begin
            n_pc = r_pc + t_pc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_WAIT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // A taken request always starts the base reduction.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_ACCEPT && i_status.req_valid) |=> (r_pc == PC_RED_SET))
        else $error("request taken but reduction did not start");

    // The step counter stays inside the program.
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= PC_LAST)
        else $error("step counter left the program");

    // A finished square on a clear exponent bit skips the multiply.
    a_skip_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_SQR_DONE && !i_status.ebit) |=> (r_pc == PC_NEXT))
        else $error("multiply not skipped on a clear exponent bit");

endmodule : mexp_sequencer
`default_nettype wire

[rtl/core/mexp_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mexp_datapath
// Operand registers, bit-serial modular multiplier and output register.
// ----------------------------------------------------------------------------
module mexp_datapath
    import mexp_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_ctrl   i_ctrl,
    input  wire     i_req_valid,
    input  t_word   i_base,
    input  t_word   i_exponent,
    input  t_word   i_modulus,
    input  wire     i_out_ready,
    output t_status o_status,
    output logic    o_out_valid,
    output t_word   o_residue
);

    // Operand and loop registers.
    t_word r_m;
    t_word r_b;
    t_word r_e;
    t_word r_x;
    t_word r_acc;
    t_word r_a;
    t_word r_y;
    t_word r_p;
    t_cnt  r_cnt;
    t_cnt  r_bitcnt;
    t_word r_res;
    logic  r_out_valid;

    t_word                  w_one;
    logic [OPERAND_WIDTH:0] w_dbl;
    t_word                  w_dbl_red;
    logic [OPERAND_WIDTH:0] w_sum;
    t_word                  w_sum_red;
    t_word                  w_step;
    logic                   w_out_busy;
    logic                   w_accept;

    // 1 mod m: zero for a modulus of one.
    assign w_one = (r_m == t_word'(1)) ? '0 : t_word'(1);

    // One multiplier step: p = 2p mod m, then add a mod m if the y bit is set.
    always_comb begin
        w_dbl     = {1'b0, r_p} + {1'b0, r_p};
        w_dbl_red = (w_dbl >= {1'b0, r_m}) ? t_word'(w_dbl - {1'b0, r_m})
                                           : t_word'(w_dbl);
        w_sum     = {1'b0, w_dbl_red} + {1'b0, r_a};
        w_sum_red = (w_sum >= {1'b0, r_m}) ? t_word'(w_sum - {1'b0, r_m})
                                           : t_word'(w_sum);
        w_step    = r_y[OPERAND_WIDTH-1] ? w_sum_red : w_dbl_red;
    end

    assign w_out_busy = r_out_valid && !i_out_ready;
    assign w_accept   = (i_ctrl.op == OP_ACCEPT) && i_req_valid;

    // Operand registers follow the current control word.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_ACCEPT: begin
                if (w_accept) begin
                    r_m <= i_modulus;
                    r_b <= i_base;
                    r_e <= i_exponent;
                end
            end
            OP_SETUP_RED: begin
                r_acc <= w_one;
                r_a   <= w_one;
                r_y   <= r_b;
                r_p   <= '0;
                r_cnt <= CNT_START;
            end
            OP_MUL_STEP: begin
                r_p   <= w_step;
                r_y   <= {r_y[OPERAND_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - t_cnt'(1);
            end
            OP_STORE_X: begin
                r_x      <= r_p;
                r_bitcnt <= CNT_START;
            end
            OP_SETUP_SQR: begin
                r_a   <= r_acc;
                r_y   <= r_acc;
                r_p   <= '0;
                r_cnt <= CNT_START;
            end
            OP_SETUP_MULX: begin
                r_a   <= r_x;
                r_y   <= r_acc;
                r_p   <= '0;
                r_cnt <= CNT_START;
            end
            OP_STORE_ACC: begin
                r_acc <= r_p;
            end
            OP_NEXT_BIT: begin
                r_e      <= {r_e[OPERAND_WIDTH-2:0], 1'b0};
                r_bitcnt <= r_bitcnt - t_cnt'(1);
            end
            OP_EMIT: begin
                if (!w_out_busy) begin
                    r_res <= (r_m == '0) ? '0 : r_acc;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: loaded by the emit step, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.op == OP_EMIT && !w_out_busy) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status = '{
        req_valid: i_req_valid,
        cnt_nz:    (r_cnt != '0),
        ebit:      r_e[OPERAND_WIDTH-1],
        bits_left: (r_bitcnt != '0),
        out_busy:  w_out_busy
    };
    assign o_out_valid = r_out_valid;
    assign o_residue   = r_res;

    // A multiplier step keeps the partial product reduced.
    a_step_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_ctrl.op) == OP_MUL_STEP && r_m != '0) |-> (r_p < r_m))
        else $error("partial product not reduced");

    // An emit step with a free output register presents a result next cycle.
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_EMIT && !w_out_busy) |=> r_out_valid)
        else $error("emit did not present a result");

    // A zero modulus always gives a zero residue.
    a_zero_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.op == OP_EMIT && !w_out_busy && r_m == '0) |=> (r_res == '0))
        else $error("zero modulus gave a nonzero residue");

endmodule : mexp_datapath
`default_nettype wire
